// ===== rtl/core/tile_map_quad_generator_assert.svh =====
// Assertion helpers for the tile map quad generator.
// Both sample on clk and are switched off while rst_n is low.
`ifndef TILE_MAP_QUAD_GENERATOR_ASSERT_SVH
`define TILE_MAP_QUAD_GENERATOR_ASSERT_SVH

// Property checked on every clock edge outside reset
`define TMQG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked only while a given condition holds
`define TMQG_ASSERT_WHEN(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);

`endif

// ===== rtl/core/tmqg_pkg.sv =====
package tmqg_pkg;

  // Field and register widths
  localparam int REG_W   = 9;
  localparam int NUM_W   = 16;
  localparam int IDX_W   = 8;
  localparam int POS_W   = 17;
  localparam int TEXV_W  = 25;
  localparam int SLOT_W  = 3;
  localparam int CIDX_W  = 3;
  localparam int STEP_W  = 4;

  // Largest map dimension and largest tile / sheet setting
  localparam int MAX_DIM = 256;
  localparam logic [REG_W-1:0] MAX_DIM_V = REG_W'(MAX_DIM);
  localparam logic [REG_W-1:0] MAX_SIZE  = REG_W'(256);

  // Vertices per tile
  localparam int VERTS = 6;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(VERTS - 1);

  // Divider steps (one quotient bit each) and multiplier steps
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(NUM_W - 1);
  localparam logic [STEP_W-1:0] MUL_PX   = STEP_W'(0);
  localparam logic [STEP_W-1:0] MUL_PY   = STEP_W'(1);
  localparam logic [STEP_W-1:0] MUL_TU   = STEP_W'(2);
  localparam logic [STEP_W-1:0] MUL_TV   = STEP_W'(3);

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_MAP_WIDTH     = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] REG_MAP_HEIGHT    = CIDX_W'(1);
  localparam logic [CIDX_W-1:0] REG_TILE_WIDTH    = CIDX_W'(2);
  localparam logic [CIDX_W-1:0] REG_TILE_HEIGHT   = CIDX_W'(3);
  localparam logic [CIDX_W-1:0] REG_SHEET_COLUMNS = CIDX_W'(4);

  // Zero acts as one, anything above the limit saturates
  function automatic logic [REG_W-1:0] clamp_reg(input logic [REG_W-1:0] v,
                                                 input logic [REG_W-1:0] hi);
    logic [REG_W-1:0] r;
    if (v == '0) r = REG_W'(1);
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  // Quad corner order 0,1,2,0,2,3: right edge used by corners 1 and 2
  function automatic logic slot_x_hi(input logic [SLOT_W-1:0] slot);
    logic r;
    case (slot)
      3'd1, 3'd2, 3'd4: r = 1'b1;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

  // Bottom edge used by corners 2 and 3
  function automatic logic slot_y_hi(input logic [SLOT_W-1:0] slot);
    logic r;
    case (slot)
      3'd2, 3'd4, 3'd5: r = 1'b1;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/tile_map_quad_generator.sv =====
// Tile map quad generator. Takes one tile number per map cell in column-major
// order (row fastest) and returns six vertex beats, the triangles 0,1,2 and
// 0,2,3 of that cell's quad, each with screen position and sheet texture
// coordinate. A tile goes through an accept state, the radix-2 divider that splits
// the tile number by sheet_columns, the single 16x9 multiplier, and the emit
// state that sends the six vertices through the output register. in_ready is
// high only between tiles; the last vertex may still wait at the output while
// the next tile is taken. Configuration must be written only while no tile is
// in flight, by the user; the block does not enforce it. cfg_ready is always high.
module tile_map_quad_generator
  import tmqg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic [NUM_W-1:0]    in_tile_number,

  output logic                out_valid,
  input  logic                out_ready,
  output logic [POS_W-1:0]    out_pos_x,
  output logic [POS_W-1:0]    out_pos_y,
  output logic [POS_W-1:0]    out_tex_u,
  output logic [TEXV_W-1:0]   out_tex_v,
  output logic [SLOT_W-1:0]   out_vertex_slot,
  output logic                out_last_vertex,

  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [REG_W-1:0]    cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic [REG_W-1:0]  map_width_r, map_height_r, tile_width_r, tile_height_r;
  logic [REG_W-1:0]  sheet_columns_r;
  logic [IDX_W-1:0]  col_r, col_nxt, row_r, row_nxt;

  // Divider: quo_r shifts the dividend out and the quotient in
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [REG_W-1:0]  rem_r, rem_nxt;

  logic [POS_W-1:0]  px0_r, px0_nxt, py0_r, py0_nxt, tu0_r, tu0_nxt;
  logic [TEXV_W-1:0] tv0_r, tv0_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]  pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt, tex_u_r, tex_u_nxt;
  logic [TEXV_W-1:0] tex_v_r, tex_v_nxt;
  logic [SLOT_W-1:0] vslot_r, vslot_nxt;
  logic              last_r, last_nxt;

  logic [REG_W-1:0]  mw_eff, mh_eff, tw_eff, th_eff, sc_eff;
  logic [REG_W:0]    trial;
  logic              trial_ge;
  logic [NUM_W-1:0]  mul_a;
  logic [REG_W-1:0]  mul_b;
  logic [TEXV_W-1:0] product;
  logic [REG_W-1:0]  row_inc, col_inc;
  logic              in_fire, load_out;

  // Effective register values
  assign mw_eff = clamp_reg(map_width_r, MAX_DIM_V);
  assign mh_eff = clamp_reg(map_height_r, MAX_DIM_V);
  assign tw_eff = clamp_reg(tile_width_r, MAX_SIZE);
  assign th_eff = clamp_reg(tile_height_r, MAX_SIZE);
  assign sc_eff = clamp_reg(sheet_columns_r, MAX_SIZE);

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign load_out  = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  // Divider step: compare and subtract
  assign trial    = {rem_r, quo_r[NUM_W-1]};
  assign trial_ge = (trial >= {1'b0, sc_eff});

  // Shared multiplier operand select
  always_comb begin
    case (step_r)
      MUL_PX:  begin mul_a = NUM_W'(col_r);  mul_b = tw_eff; end
      MUL_PY:  begin mul_a = NUM_W'(row_r);  mul_b = th_eff; end
      MUL_TU:  begin mul_a = NUM_W'(rem_r);  mul_b = tw_eff; end
      default: begin mul_a = quo_r;          mul_b = th_eff; end
    endcase
  end
  assign product = TEXV_W'(mul_a * mul_b);

  assign row_inc = REG_W'(row_r) + REG_W'(1);
  assign col_inc = REG_W'(col_r) + REG_W'(1);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    slot_nxt  = slot_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    px0_nxt   = px0_r;
    py0_nxt   = py0_r;
    tu0_nxt   = tu0_r;
    tv0_nxt   = tv0_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          quo_nxt   = in_tile_number;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = trial_ge ? REG_W'(trial - {1'b0, sc_eff}) : trial[REG_W-1:0];
        quo_nxt  = {quo_r[NUM_W-2:0], trial_ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == DIV_LAST) begin
          step_nxt  = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        step_nxt = step_r + STEP_W'(1);
        case (step_r)
          MUL_PX:  px0_nxt = product[POS_W-1:0];
          MUL_PY:  py0_nxt = product[POS_W-1:0];
          MUL_TU:  tu0_nxt = product[POS_W-1:0];
          default: tv0_nxt = product;
        endcase
        if (step_r == MUL_TV) begin
          // advance the map position, row fastest
          if (row_inc >= mh_eff) begin
            row_nxt = '0;
            col_nxt = (col_inc >= mw_eff) ? '0 : col_inc[IDX_W-1:0];
          end else begin
            row_nxt = row_inc[IDX_W-1:0];
          end
          slot_nxt  = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          slot_nxt = slot_r + SLOT_W'(1);
          if (slot_r == LAST_SLOT) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register: one vertex per beat
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    tex_u_nxt     = tex_u_r;
    tex_v_nxt     = tex_v_r;
    vslot_nxt     = vslot_r;
    last_nxt      = last_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      pos_x_nxt = slot_x_hi(slot_r) ? POS_W'(px0_r + POS_W'(tw_eff)) : px0_r;
      tex_u_nxt = slot_x_hi(slot_r) ? POS_W'(tu0_r + POS_W'(tw_eff)) : tu0_r;
      pos_y_nxt = slot_y_hi(slot_r) ? POS_W'(py0_r + POS_W'(th_eff)) : py0_r;
      tex_v_nxt = slot_y_hi(slot_r) ? TEXV_W'(tv0_r + TEXV_W'(th_eff)) : tv0_r;
      vslot_nxt = slot_r;
      last_nxt  = (slot_r == LAST_SLOT);
    end
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      step_r          <= '0;
      slot_r          <= '0;
      col_r           <= '0;
      row_r           <= '0;
      out_valid_r     <= 1'b0;
      map_width_r     <= REG_W'(16);
      map_height_r    <= REG_W'(16);
      tile_width_r    <= REG_W'(32);
      tile_height_r   <= REG_W'(32);
      sheet_columns_r <= REG_W'(8);
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      slot_r      <= slot_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MAP_WIDTH:     map_width_r     <= cfg_data;
          REG_MAP_HEIGHT:    map_height_r    <= cfg_data;
          REG_TILE_WIDTH:    tile_width_r    <= cfg_data;
          REG_TILE_HEIGHT:   tile_height_r   <= cfg_data;
          REG_SHEET_COLUMNS: sheet_columns_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    px0_r   <= px0_nxt;
    py0_r   <= py0_nxt;
    tu0_r   <= tu0_nxt;
    tv0_r   <= tv0_nxt;
    pos_x_r <= pos_x_nxt;
    pos_y_r <= pos_y_nxt;
    tex_u_r <= tex_u_nxt;
    tex_v_r <= tex_v_nxt;
    vslot_r <= vslot_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pos_x       = pos_x_r;
  assign out_pos_y       = pos_y_r;
  assign out_tex_u       = tex_u_r;
  assign out_tex_v       = tex_v_r;
  assign out_vertex_slot = vslot_r;
  assign out_last_vertex = last_r;

  // Checks
  `include "tile_map_quad_generator_assert.svh"

  `TMQG_ASSERT(a_accept_starts_div, in_fire |=> (state_r == ST_DIV && step_r == '0), "accepted tile did not start the divider")
  `TMQG_ASSERT_WHEN(a_rem_below_divisor, state_r == ST_DIV, rem_r < sc_eff, "divider remainder reached the divisor")
  `TMQG_ASSERT_WHEN(a_last_matches_slot, out_valid_r, last_r == (vslot_r == LAST_SLOT), "last_vertex out of step with vertex_slot")
  `TMQG_ASSERT_WHEN(a_idle_pending_is_last, state_r == ST_IDLE && out_valid_r, last_r, "vertex other than the last pending between tiles")

endmodule
